>>> sv/lru_residency_tracker_defines.svh
// Assertion macros used by the tracker datapath.
`ifndef LRU_RESIDENCY_TRACKER_DEFINES_SVH
`define LRU_RESIDENCY_TRACKER_DEFINES_SVH

// Plain property, checked on every clock outside reset.
`define LRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, checked on every clock outside reset.
`define LRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define LRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lrt_pkg.sv
package lrt_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int KEY_BITS_DEF  = 32;
    localparam int KEY_PORT_BITS = 32;
    localparam int KEY_WIDE_BITS = 64;
    localparam int STAMP_BITS    = 64;
    localparam int CAP_BITS      = 7;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } lrt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic occ_zero;
        logic out_free;
    } lrt_status_t;

endpackage

>>> sv/lru_residency_tracker.sv
// Fully associative residency tracker with exact LRU replacement. Each key beat is
// looked up against all resident entries; a hit refreshes the entry's use stamp
// (is_new = 0), a miss inserts the key into the next free slot or, once occupancy
// reaches capacity_in_use (0 acts as 1, values above ENTRIES act as ENTRIES),
// replaces the entry with the oldest stamp and reports its key. Entries fill in slot
// order and are never freed, so occupancy alone marks which slots are valid and no
// clearing pass follows reset. The next key waits until the current one commits:
// the key and stamp memories have one read port and are walked one entry per
// cycle (skipped with an empty table), a drain state lets the last read land, and
// a decide state commits the update once the output register is free. The result
// sits in an output register, so a new key is accepted while the previous result
// is still stalled. capacity_in_use resets to 64; cfg_ready is always high.
module lru_residency_tracker
#(
    parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrt_pkg::CAP_BITS-1:0]        capacity_in_use,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lrt_pkg::KEY_PORT_BITS-1:0]   key,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_new,
    output logic                                evicted_valid,
    output logic [lrt_pkg::KEY_PORT_BITS-1:0]   evicted_key
);

    lrt_pkg::lrt_cmd_t    cmd;
    lrt_pkg::lrt_status_t status;

    assign cfg_ready = 1'b1;

    lrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lrt_datapath
    #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (capacity_in_use),
        .key           (key),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .is_new        (is_new),
        .evicted_valid (evicted_valid),
        .evicted_key   (evicted_key)
    );

endmodule

>>> sv/lrt_ctrl.sv
module lrt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lrt_pkg::lrt_status_t status,
    output lrt_pkg::lrt_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        state_next = state_reg;
        stall_next = stall_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    stall_next = 1'b1;
                    state_next = status.occ_zero ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    stall_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

endmodule

>>> sv/lrt_datapath.sv
`include "lru_residency_tracker_defines.svh"

module lrt_datapath
#(
    parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrt_pkg::lrt_cmd_t                   cmd,
    output lrt_pkg::lrt_status_t                status,
    input  logic                                cfg_we,
    input  logic [lrt_pkg::CAP_BITS-1:0]        cfg_data,
    input  logic [lrt_pkg::KEY_PORT_BITS-1:0]   key,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                is_new,
    output logic                                evicted_valid,
    output logic [lrt_pkg::KEY_PORT_BITS-1:0]   evicted_key
);

    localparam int AW   = $clog2(ENTRIES);
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > lrt_pkg::CAP_BITS) ? OW : lrt_pkg::CAP_BITS;
    localparam int SB   = lrt_pkg::STAMP_BITS;

    logic [KEY_BITS-1:0] key_mem   [ENTRIES];
    logic [SB-1:0]       stamp_mem [ENTRIES];

    logic [lrt_pkg::CAP_BITS-1:0] cap_reg;
    logic [OW-1:0]                occ_reg;
    logic [OW-1:0]                occ_next;
    logic [SB-1:0]                stamp_cnt_reg;
    logic [SB-1:0]                stamp_cnt_next;
    logic [AW-1:0]                idx_reg;
    logic [AW-1:0]                idx_next;
    logic                         rd_valid_reg;
    logic [AW-1:0]                rd_idx_reg;
    logic [KEY_BITS-1:0]          key_rd_reg;
    logic [SB-1:0]                stamp_rd_reg;

    logic                         hit_reg;
    logic                         hit_next;
    logic [AW-1:0]                hit_idx_reg;
    logic [AW-1:0]                hit_idx_next;
    logic                         have_reg;
    logic                         have_next;
    logic [SB-1:0]                min_reg;
    logic [SB-1:0]                min_next;
    logic [AW-1:0]                min_idx_reg;
    logic [AW-1:0]                min_idx_next;
    logic [KEY_BITS-1:0]          min_key_reg;
    logic [KEY_BITS-1:0]          min_key_next;
    logic [KEY_BITS-1:0]          key_reg;
    logic [KEY_BITS-1:0]          key_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              is_new_reg;
    logic                              is_new_next;
    logic                              evv_reg;
    logic                              evv_next;
    logic [lrt_pkg::KEY_PORT_BITS-1:0] evk_reg;
    logic [lrt_pkg::KEY_PORT_BITS-1:0] evk_next;

    logic [lrt_pkg::KEY_WIDE_BITS-1:0] key_wide;
    logic [lrt_pkg::KEY_WIDE_BITS-1:0] ev_wide;
    logic [CMPW-1:0]                   cap_ext;
    logic [CMPW-1:0]                   eff_cap;
    logic                              full;
    logic                              out_free;
    logic                              key_we;
    logic                              stamp_we;
    logic [AW-1:0]                     wr_addr;

    // key trimmed to KEY_BITS, evicted key zero-extended then cut to port width
    always_comb
    begin
        key_wide = lrt_pkg::KEY_WIDE_BITS'(key);
        ev_wide  = '0;
        ev_wide[KEY_BITS-1:0] = min_key_reg;
    end

    always_comb
    begin
        cap_ext = CMPW'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > CMPW'(ENTRIES))
        begin
            eff_cap = CMPW'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full = (CMPW'(occ_reg) >= eff_cap) && have_reg;
    end

    assign out_free         = !out_valid_reg || !out_stall;
    assign status.out_free  = out_free;
    assign status.occ_zero  = (occ_reg == '0);
    assign status.scan_last = ((OW'(idx_reg) + OW'(1)) == occ_reg);

    // scan accumulation: first matching key, oldest stamp (lowest index on ties)
    always_comb
    begin
        key_next     = key_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        have_next    = have_reg;
        min_next     = min_reg;
        min_idx_next = min_idx_reg;
        min_key_next = min_key_reg;
        idx_next     = idx_reg;
        if (cmd.start)
        begin
            key_next  = key_wide[KEY_BITS-1:0];
            hit_next  = 1'b0;
            have_next = 1'b0;
            idx_next  = '0;
        end
        else
        begin
            if (cmd.scan)
            begin
                idx_next = idx_reg + AW'(1);
            end
            if (rd_valid_reg)
            begin
                if (!hit_reg && (key_rd_reg == key_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                end
                if (!have_reg || (stamp_rd_reg < min_reg))
                begin
                    have_next    = 1'b1;
                    min_next     = stamp_rd_reg;
                    min_idx_next = rd_idx_reg;
                    min_key_next = key_rd_reg;
                end
            end
        end
    end

    // commit: update the table and load the result beat
    always_comb
    begin
        occ_next       = occ_reg;
        stamp_cnt_next = stamp_cnt_reg;
        key_we         = 1'b0;
        stamp_we       = 1'b0;
        wr_addr        = occ_reg[AW-1:0];
        out_valid_next = out_valid_reg && out_stall;
        is_new_next    = is_new_reg;
        evv_next       = evv_reg;
        evk_next       = evk_reg;
        if (cmd.commit)
        begin
            stamp_we       = 1'b1;
            stamp_cnt_next = stamp_cnt_reg + SB'(1);
            out_valid_next = 1'b1;
            priority if (hit_reg)
            begin
                wr_addr     = hit_idx_reg;
                is_new_next = 1'b0;
                evv_next    = 1'b0;
                evk_next    = '0;
            end
            else if (full)
            begin
                wr_addr     = min_idx_reg;
                key_we      = 1'b1;
                is_new_next = 1'b1;
                evv_next    = 1'b1;
                evk_next    = ev_wide[lrt_pkg::KEY_PORT_BITS-1:0];
            end
            else
            begin
                key_we      = 1'b1;
                occ_next    = occ_reg + OW'(1);
                is_new_next = 1'b1;
                evv_next    = 1'b0;
                evk_next    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_rd_reg   <= key_mem[idx_reg];
        stamp_rd_reg <= stamp_mem[idx_reg];
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (stamp_we)
        begin
            stamp_mem[wr_addr] <= stamp_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lrt_pkg::CAP_RESET;
            occ_reg       <= '0;
            stamp_cnt_reg <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            occ_reg       <= occ_next;
            stamp_cnt_reg <= stamp_cnt_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= cmd.scan;
            hit_reg       <= hit_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= idx_reg;
        key_reg     <= key_next;
        hit_idx_reg <= hit_idx_next;
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
        min_key_reg <= min_key_next;
        is_new_reg  <= is_new_next;
        evv_reg     <= evv_next;
        evk_reg     <= evk_next;
    end

    assign out_valid     = out_valid_reg;
    assign is_new        = is_new_reg;
    assign evicted_valid = evv_reg;
    assign evicted_key   = evk_reg;

    `LRT_ASSERT(a_occ_bound, occ_reg <= OW'(ENTRIES), "occupancy above table size")
    `LRT_ASSERT_IMP(a_commit_free, cmd.commit, out_free, "commit over a held result beat")
    `LRT_ASSERT_NXT(a_hit_occ, cmd.commit && hit_reg, $stable(occ_reg), "hit changed occupancy")
    `LRT_ASSERT_NXT(a_stamp_step, cmd.commit, stamp_cnt_reg == $past(stamp_cnt_reg) + SB'(1),
        "stamp counter did not advance on commit")
    `LRT_ASSERT_IMP(a_evict_new, out_valid_reg && evv_reg, is_new_reg, "eviction without insert")

endmodule
